FILE: hw/rtl/scg_pkg.sv
package scg_pkg;

  localparam int MAX_SEGMENT_DEF = 64;
  localparam int LEN_W           = 9;
  localparam int POS_W           = 11;
  localparam int SPAN_W          = 9;
  localparam int PROD_W          = 22;
  localparam int NUM_CHAN        = 3;
  localparam int QUEUE_DEPTH     = 2;

  typedef struct packed {
    logic [8:0] seg_begin;
    logic [6:0] seg_length;
    logic [7:0] start_red;
    logic [7:0] start_green;
    logic [7:0] start_blue;
    logic [7:0] end_red;
    logic [7:0] end_green;
    logic [7:0] end_blue;
    logic [8:0] center_pos;
    logic [7:0] blend_width;
  } req_t;

  typedef struct packed {
    logic [9:0] led_index;
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;
    logic       last_pixel;
  } pix_t;

  typedef struct packed {
    logic [7:0]        c1;
    logic [7:0]        c2;
    logic              neg;
    logic [7:0]        step_q;
    logic [SPAN_W-1:0] step_r;
    logic [7:0]        init_q;
    logic [SPAN_W-1:0] init_r;
  } chan_t;

  typedef struct packed {
    logic [8:0]              seg_begin;
    logic [LEN_W-1:0]        len;
    logic signed [POS_W-1:0] blend_s;
    logic signed [POS_W-1:0] blend_e;
    logic [SPAN_W-1:0]       span;
    chan_t [NUM_CHAN-1:0]    chan;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: hw/rtl/scg_front.sv
module scg_front #(
  parameter int MAX_SEGMENT = scg_pkg::MAX_SEGMENT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  scg_pkg::req_t   req,
  input  scg_pkg::qstat_t qstat,
  output logic            push,
  output scg_pkg::job_t   job
);

  localparam int LEN_W  = scg_pkg::LEN_W;
  localparam int POS_W  = scg_pkg::POS_W;
  localparam int SPAN_W = scg_pkg::SPAN_W;
  localparam int PROD_W = scg_pkg::PROD_W;
  localparam int NCH    = scg_pkg::NUM_CHAN;
  localparam logic [3:0] DIVA_LAST = 4'd7;
  localparam logic [3:0] DIVQ_LAST = 4'd15;

  typedef enum logic [6:0] {
    IDLE  = 7'b0000001,
    MULT  = 7'b0000010,
    ROUND = 7'b0000100,
    SCALE = 7'b0001000,
    DIVA  = 7'b0010000,
    DIVQ  = 7'b0100000,
    PUSH  = 7'b1000000
  } state_t;

  state_t                    state;
  scg_pkg::req_t             req_r;
  logic [LEN_W-1:0]          len;
  logic signed [PROD_W-1:0]  prod_s;
  logic signed [PROD_W-1:0]  prod_e;
  logic signed [POS_W-1:0]   blend_s;
  logic signed [POS_W-1:0]   blend_e;
  logic [SPAN_W-1:0]         span;
  logic [7:0]                t0;
  logic [3:0]                cnt;
  logic [7:0]                dabs   [NCH];
  logic                      neg    [NCH];
  logic [15:0]               scaled [NCH];
  logic [15:0]               xr     [NCH];
  logic [SPAN_W-1:0]         rr     [NCH];
  logic [7:0]                step_q [NCH];
  logic [SPAN_W-1:0]         step_r [NCH];
  logic [7:0]                init_q [NCH];
  logic [SPAN_W-1:0]         init_r [NCH];

  logic [LEN_W-1:0]          len_ext;
  logic [LEN_W-1:0]          len_sat;
  logic signed [11:0]        f_s;
  logic signed [11:0]        f_e;
  logic signed [POS_W-1:0]   s_val;
  logic signed [POS_W-1:0]   e_raw;
  logic signed [POS_W-1:0]   e_clip;
  logic signed [POS_W-1:0]   len_s;
  logic [7:0]                c1     [NCH];
  logic [7:0]                c2     [NCH];
  logic [8:0]                diff   [NCH];
  logic [SPAN_W:0]           rs     [NCH];
  logic                      ge     [NCH];
  logic [15:0]               xr_next[NCH];
  logic [SPAN_W-1:0]         rr_next[NCH];

  function automatic logic signed [POS_W-1:0] round512(input logic signed [PROD_W-1:0] n);
    logic [PROD_W-1:0]       mag;
    logic [PROD_W-1:0]       q;
    logic signed [POS_W-1:0] r;
    mag = n[PROD_W-1] ? PROD_W'(-n) : PROD_W'(n);
    q   = (mag + PROD_W'(256)) >> 9;
    r   = $signed(q[POS_W-1:0]);
    return n[PROD_W-1] ? -r : r;
  endfunction

  assign len_ext = LEN_W'(req.seg_length);
  assign len_sat = (len_ext > LEN_W'(MAX_SEGMENT)) ? LEN_W'(MAX_SEGMENT) : len_ext;

  assign f_s = $signed({2'b00, req_r.center_pos, 1'b0}) - $signed({4'b0000, req_r.blend_width});
  assign f_e = $signed({2'b00, req_r.center_pos, 1'b0}) + $signed({4'b0000, req_r.blend_width});

  assign s_val  = round512(prod_s);
  assign e_raw  = round512(prod_e);
  assign len_s  = $signed({{(POS_W-LEN_W){1'b0}}, len});
  assign e_clip = (e_raw > len_s) ? len_s : e_raw;

  assign c1[0] = req_r.start_red;
  assign c1[1] = req_r.start_green;
  assign c1[2] = req_r.start_blue;
  assign c2[0] = req_r.end_red;
  assign c2[1] = req_r.end_green;
  assign c2[2] = req_r.end_blue;

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      diff[k]    = {1'b0, c2[k]} - {1'b0, c1[k]};
      rs[k]      = {rr[k], xr[k][15]};
      ge[k]      = rs[k] >= {1'b0, span};
      rr_next[k] = ge[k] ? SPAN_W'(rs[k] - {1'b0, span}) : rs[k][SPAN_W-1:0];
      xr_next[k] = {xr[k][14:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (req_valid && (len_sat != '0)) begin
            req_r <= req;
            len   <= len_sat;
            state <= MULT;
          end
        end
        MULT: begin
          prod_s <= PROD_W'($signed({1'b0, len})) * PROD_W'(f_s);
          prod_e <= PROD_W'($signed({1'b0, len})) * PROD_W'(f_e);
          state  <= ROUND;
        end
        ROUND: begin
          blend_s <= s_val;
          blend_e <= e_clip;
          span    <= SPAN_W'(e_clip - s_val);
          t0      <= s_val[POS_W-1] ? 8'(-s_val) : 8'd0;
          for (int k = 0; k < NCH; k++) begin
            neg[k]  <= diff[k][8];
            dabs[k] <= diff[k][8] ? 8'(-diff[k]) : diff[k][7:0];
          end
          state <= SCALE;
        end
        SCALE: begin
          for (int k = 0; k < NCH; k++) begin
            scaled[k] <= 16'(dabs[k]) * 16'(t0);
            xr[k]     <= {dabs[k], 8'd0};
            rr[k]     <= '0;
          end
          cnt   <= '0;
          state <= DIVA;
        end
        DIVA: begin
          if (cnt == DIVA_LAST) begin
            for (int k = 0; k < NCH; k++) begin
              step_q[k] <= xr_next[k][7:0];
              step_r[k] <= rr_next[k];
              xr[k]     <= scaled[k];
              rr[k]     <= '0;
            end
            cnt   <= '0;
            state <= DIVQ;
          end else begin
            cnt <= cnt + 4'd1;
            for (int k = 0; k < NCH; k++) begin
              xr[k] <= xr_next[k];
              rr[k] <= rr_next[k];
            end
          end
        end
        DIVQ: begin
          cnt <= cnt + 4'd1;
          for (int k = 0; k < NCH; k++) begin
            xr[k] <= xr_next[k];
            rr[k] <= rr_next[k];
          end
          if (cnt == DIVQ_LAST) begin
            for (int k = 0; k < NCH; k++) begin
              init_q[k] <= xr_next[k][7:0];
              init_r[k] <= rr_next[k];
            end
            state <= PUSH;
          end
        end
        PUSH: begin
          if (!qstat.full) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign req_stall = (state != IDLE);
  assign push      = (state == PUSH) && !qstat.full;

  always_comb begin
    job.seg_begin = req_r.seg_begin;
    job.len       = len;
    job.blend_s   = blend_s;
    job.blend_e   = blend_e;
    job.span      = span;
    for (int k = 0; k < NCH; k++) begin
      job.chan[k].c1     = c1[k];
      job.chan[k].c2     = c2[k];
      job.chan[k].neg    = neg[k];
      job.chan[k].step_q = step_q[k];
      job.chan[k].step_r = step_r[k];
      job.chan[k].init_q = init_q[k];
      job.chan[k].init_r = init_r[k];
    end
  end

endmodule

FILE: hw/rtl/scg_queue.sv
module scg_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  scg_pkg::job_t   wr_data,
  input  logic            pop,
  output scg_pkg::job_t   rd_data,
  output scg_pkg::qstat_t qstat
);

  localparam int DEPTH = scg_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  scg_pkg::job_t    mem [DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] fill;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + PTR_W'(1);
      end
      if (pop) begin
        rp <= (rp == PTR_W'(DEPTH - 1)) ? '0 : rp + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  assign rd_data     = mem[rp];
  assign qstat.full  = (fill == CNT_W'(DEPTH));
  assign qstat.empty = (fill == '0);

endmodule

FILE: hw/rtl/scg_back.sv
module scg_back (
  input  logic            clk,
  input  logic            rst,
  input  scg_pkg::qstat_t qstat,
  output logic            pop,
  input  scg_pkg::job_t   job,
  output logic            pix_valid,
  input  logic            pix_stall,
  output scg_pkg::pix_t   pix
);

  localparam int LEN_W  = scg_pkg::LEN_W;
  localparam int POS_W  = scg_pkg::POS_W;
  localparam int SPAN_W = scg_pkg::SPAN_W;
  localparam int NCH    = scg_pkg::NUM_CHAN;

  logic                    busy;
  scg_pkg::job_t           cur;
  logic [LEN_W-1:0]        idx;
  logic [7:0]              q      [NCH];
  logic [SPAN_W-1:0]       r      [NCH];

  logic                    load;
  logic                    fire;
  logic                    last;
  logic                    at_end;
  logic                    at_start;
  logic                    adv;
  logic signed [POS_W-1:0] idx_s;
  logic [SPAN_W:0]         rsum   [NCH];
  logic                    wrap   [NCH];
  logic [SPAN_W-1:0]       r_next [NCH];
  logic [7:0]              q_next [NCH];
  logic [7:0]              val    [NCH];
  scg_pkg::pix_t           pix_c;

  assign load     = !busy && !qstat.empty;
  assign pop      = load;
  assign fire     = busy && (!pix_valid || !pix_stall);
  assign idx_s    = $signed({{(POS_W-LEN_W){1'b0}}, idx});
  assign at_end   = cur.blend_e <= idx_s;
  assign at_start = idx_s <= cur.blend_s;
  assign adv      = idx_s >= cur.blend_s;
  assign last     = (idx == cur.len - LEN_W'(1));

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      rsum[k]   = {1'b0, r[k]} + {1'b0, cur.chan[k].step_r};
      wrap[k]   = rsum[k] >= {1'b0, cur.span};
      r_next[k] = wrap[k] ? SPAN_W'(rsum[k] - {1'b0, cur.span}) : rsum[k][SPAN_W-1:0];
      q_next[k] = q[k] + cur.chan[k].step_q + 8'(wrap[k]);
      if (at_end) begin
        val[k] = cur.chan[k].c2;
      end else if (at_start) begin
        val[k] = cur.chan[k].c1;
      end else begin
        val[k] = cur.chan[k].neg ? cur.chan[k].c1 - q[k] : cur.chan[k].c1 + q[k];
      end
    end
    pix_c.led_index  = 10'(cur.seg_begin) + 10'(idx);
    pix_c.pix_red    = val[0];
    pix_c.pix_green  = val[1];
    pix_c.pix_blue   = val[2];
    pix_c.last_pixel = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        cur  <= job;
        idx  <= '0;
        for (int k = 0; k < NCH; k++) begin
          q[k] <= job.chan[k].init_q;
          r[k] <= job.chan[k].init_r;
        end
      end else if (fire) begin
        idx <= idx + LEN_W'(1);
        if (adv) begin
          for (int k = 0; k < NCH; k++) begin
            q[k] <= q_next[k];
            r[k] <= r_next[k];
          end
        end
        if (last) begin
          busy <= 1'b0;
        end
      end
      if (fire) begin
        pix_valid <= 1'b1;
        pix       <= pix_c;
      end else if (!pix_stall) begin
        pix_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/segment_color_gradient.sv
// Segment colour gradient.
// The req channel takes one word per LED segment: first index, length, two
// colours, blend centre and blend width. The pix channel gives one word per
// LED of the segment, in order, up to MAX_SEGMENT, with last_pixel set on
// the final one. A request of zero length is taken and gives nothing.
// Both channels use valid and stall; a word moves on a rising edge with
// valid high and stall low.
// The front end holds one request while it works out the blend limits and
// runs a bit-serial divider, 8 then 16 steps, for the per-channel step and
// start values. The result goes into a two-entry queue, so the front takes
// the next request while pixels still stream.
// The back end emits one pixel per cycle while the receiver does not stall.
// It loads the next segment from the queue only once the current one has
// issued its last pixel, so an idle slot separates segments.
// When the receiver stalls, the output word holds and the back end waits;
// the queue then fills and the req channel stalls in turn.
// Reset empties the queue and drops any request or pixel in flight.
module segment_color_gradient #(
  parameter int MAX_SEGMENT = scg_pkg::MAX_SEGMENT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  scg_pkg::req_t req,
  output logic          pix_valid,
  input  logic          pix_stall,
  output scg_pkg::pix_t pix
);

  scg_pkg::qstat_t qstat;
  scg_pkg::job_t   job_in;
  scg_pkg::job_t   job_out;
  logic            push;
  logic            pop;

  scg_front #(
    .MAX_SEGMENT (MAX_SEGMENT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .qstat     (qstat),
    .push      (push),
    .job       (job_in)
  );

  scg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (job_in),
    .pop     (pop),
    .rd_data (job_out),
    .qstat   (qstat)
  );

  scg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .pop       (pop),
    .job       (job_out),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix)
  );

endmodule
